FILE: rtl/lrc_pkg.sv
// Shared types and constants of the line rasterizer with display clip.
// No dependencies; every other file imports this package.
package lrc_pkg;

   localparam int COORD_W    = 16;
   localparam int ERR_W      = 17;
   localparam int ADDR_W     = 20;
   localparam int COLOR_W    = 16;
   localparam int CSR_DIM_W  = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // operation codes of an input item
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEN_COLOR      = 2'd2;

   localparam logic [CSR_DIM_W-1:0] WIDTH_RESET  = 11'd320;
   localparam logic [CSR_DIM_W-1:0] HEIGHT_RESET = 11'd240;
   localparam logic [COLOR_W-1:0]   COLOR_RESET  = 16'd0;

   // decoded command passed from the front end to the stepper
   typedef struct packed {
      logic               op;
      logic               x_neg;
      logic               y_neg;
      logic               x_major;
      logic [COORD_W-1:0] major;
      logic [COORD_W-1:0] minor;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } cmd_type;

   // one pixel leaving the stepper
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } pixel_type;

endpackage

FILE: rtl/lrc_channels.sv
// Valid/ready channel interfaces for requests and pixel responses.
// Depends on lrc_pkg for field widths.
interface lrc_req_if import lrc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [COORD_W-1:0] x_start;
   logic [COORD_W-1:0] y_start;
   logic [COORD_W-1:0] x_end;
   logic [COORD_W-1:0] y_end;

   modport source (output valid, operation, x_start, y_start, x_end, y_end, input ready);
   modport sink   (input valid, operation, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lrc_rsp_if import lrc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               in_bounds;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   logic [ADDR_W-1:0]  address;
   logic [COLOR_W-1:0] color;
   logic               last;

   modport source (output valid, in_bounds, pixel_x, pixel_y, address, color, last,
                   input ready);
   modport sink   (input valid, in_bounds, pixel_x, pixel_y, address, color, last,
                   output ready);
endinterface

FILE: rtl/lrc_front.sv
// Front end: accepts request transfers and decodes a start into deltas and directions.
// Depends on lrc_pkg and lrc_req_if.
module lrc_front import lrc_pkg::*; (
   lrc_req_if.sink     req_bus,
   output logic        push_valid,
   output cmd_type     push_cmd,
   input  logic        push_ready
);

   logic               x_neg;
   logic               y_neg;
   logic [COORD_W-1:0] dx;
   logic [COORD_W-1:0] dy;
   logic               x_major;

   always_comb begin
      x_neg   = req_bus.x_end < req_bus.x_start;
      y_neg   = req_bus.y_end < req_bus.y_start;
      dx      = x_neg ? req_bus.x_start - req_bus.x_end : req_bus.x_end - req_bus.x_start;
      dy      = y_neg ? req_bus.y_start - req_bus.y_end : req_bus.y_end - req_bus.y_start;
      x_major = dx >= dy;   // ties go to x

      push_cmd.op      = req_bus.operation;
      push_cmd.x_neg   = x_neg;
      push_cmd.y_neg   = y_neg;
      push_cmd.x_major = x_major;
      push_cmd.major   = x_major ? dx : dy;
      push_cmd.minor   = x_major ? dy : dx;
      push_cmd.x       = req_bus.x_start;
      push_cmd.y       = req_bus.y_start;
   end

   assign push_valid    = req_bus.valid;
   assign req_bus.ready = push_ready;

endmodule

FILE: rtl/lrc_cmd_queue.sv
// Two-entry command queue between the front end and the stepper.
// Depends on lrc_pkg.
module lrc_cmd_queue import lrc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    push_ready,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop_ready
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   logic                pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("command queue count exceeds depth");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QCNT_W'(QUEUE_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("command queue pointers disagree with count");
`endif

endmodule

FILE: rtl/lrc_stepper.sv
// Back end: Bresenham state and per-step pixel generation, one command per cycle while the pixel output is not stalled.
// Depends on lrc_pkg.
module lrc_stepper import lrc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_ready,
   output logic      pix_valid,
   output pixel_type pix,
   input  logic      pix_ready
);

   logic               active_ff, active_in;
   logic [COORD_W-1:0] cur_x_ff, cur_x_in;
   logic [COORD_W-1:0] cur_y_ff, cur_y_in;
   logic [ERR_W-1:0]   err_ff, err_in;
   logic [COORD_W-1:0] major_ff, major_in;
   logic [COORD_W-1:0] minor_ff, minor_in;
   logic               x_major_ff, x_major_in;
   logic               x_neg_ff, x_neg_in;
   logic               y_neg_ff, y_neg_in;
   logic [COORD_W-1:0] steps_ff, steps_in;
   logic               pv_ff, pv_in;
   pixel_type          pix_ff, pix_in;

   logic               pop;
   logic               emit;
   logic [ERR_W-1:0]   err_sum;
   logic               minor_move;
   logic [COORD_W-1:0] x_move;
   logic [COORD_W-1:0] y_move;

   assign cmd_ready = !pv_ff || pix_ready;
   assign pop       = cmd_valid && cmd_ready;
   assign emit      = pop && cmd.op == OP_STEP && active_ff;

   always_comb begin
      err_sum    = err_ff + ERR_W'(minor_ff);
      minor_move = err_sum >= ERR_W'(major_ff);
      x_move     = x_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
      y_move     = y_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;

      active_in  = active_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      err_in     = err_ff;
      major_in   = major_ff;
      minor_in   = minor_ff;
      x_major_in = x_major_ff;
      x_neg_in   = x_neg_ff;
      y_neg_in   = y_neg_ff;
      steps_in   = steps_ff;

      if (pop && cmd.op == OP_START) begin
         // load a new line, abandoning any running one
         active_in  = cmd.major != '0;
         cur_x_in   = cmd.x;
         cur_y_in   = cmd.y;
         err_in     = ERR_W'(cmd.major >> 1);
         major_in   = cmd.major;
         minor_in   = cmd.minor;
         x_major_in = cmd.x_major;
         x_neg_in   = cmd.x_neg;
         y_neg_in   = cmd.y_neg;
         steps_in   = cmd.major;
      end else if (emit) begin
         err_in   = minor_move ? err_sum - ERR_W'(major_ff) : err_sum;
         cur_x_in = (x_major_ff || minor_move) ? x_move : cur_x_ff;
         cur_y_in = (!x_major_ff || minor_move) ? y_move : cur_y_ff;
         steps_in = steps_ff - 1'b1;
         active_in = steps_ff != COORD_W'(1);
      end

      pv_in  = emit ? 1'b1 : (pix_ready ? 1'b0 : pv_ff);
      pix_in = pix_ff;
      if (emit) begin
         pix_in.x    = cur_x_in;
         pix_in.y    = cur_y_in;
         pix_in.last = steps_ff == COORD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         err_ff     <= '0;
         major_ff   <= '0;
         minor_ff   <= '0;
         x_major_ff <= 1'b0;
         x_neg_ff   <= 1'b0;
         y_neg_ff   <= 1'b0;
         steps_ff   <= '0;
         pv_ff      <= 1'b0;
      end else begin
         active_ff  <= active_in;
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         err_ff     <= err_in;
         major_ff   <= major_in;
         minor_ff   <= minor_in;
         x_major_ff <= x_major_in;
         x_neg_ff   <= x_neg_in;
         y_neg_ff   <= y_neg_in;
         steps_ff   <= steps_in;
         pv_ff      <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign pix_valid = pv_ff;
   assign pix       = pix_ff;

`ifndef SYNTHESIS
   a_active_steps: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> steps_ff != '0)
      else $error("line active with no steps left");
   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      (pop && cmd.op == OP_START && cmd.major == '0) |=> !active_ff)
      else $error("degenerate line left active");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (emit && steps_ff == COORD_W'(1)) |=> (!active_ff && pv_ff && pix_ff.last))
      else $error("final pixel did not end the line");
`endif

endmodule

FILE: rtl/lrc_pixel_out.sv
// Clip test, frame buffer address and response register for each pixel.
// Depends on lrc_pkg and lrc_rsp_if.
module lrc_pixel_out import lrc_pkg::*; #(
   parameter int MAX_W = 1024,
   parameter int MAX_H = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CSR_DIM_W-1:0] display_width,
   input  logic [CSR_DIM_W-1:0] display_height,
   input  logic [COLOR_W-1:0]   pen_color,
   input  logic                 pix_valid,
   input  pixel_type            pix,
   output logic                 pix_ready,
   lrc_rsp_if.source            rsp_bus
);

   localparam int WB     = $clog2(MAX_W + 1);
   localparam int HB     = $clog2(MAX_H + 1);
   localparam int CWW    = (WB > CSR_DIM_W) ? WB : CSR_DIM_W;
   localparam int CWH    = (HB > CSR_DIM_W) ? HB : CSR_DIM_W;
   localparam int PROD_W = HB + WB;
   localparam int SUM_W  = ((PROD_W > COORD_W) ? PROD_W : COORD_W) + 1;
   localparam int EXT_W  = (SUM_W > ADDR_W) ? SUM_W : ADDR_W;

   logic [WB-1:0]      w_eff;
   logic [HB-1:0]      h_eff;
   logic               in_clip;

   logic               s2_v_ff, s2_v_in;
   logic [COORD_W-1:0] s2_x_ff;
   logic [COORD_W-1:0] s2_y_ff;
   logic               s2_in_ff;
   logic               s2_last_ff;
   logic [PROD_W-1:0]  s2_prod_ff, s2_prod_in;

   logic               out_v_ff, out_v_in;
   logic               out_ok;
   logic               s2_ok;
   logic [EXT_W-1:0]   addr_sum;

   // saturate the clip bounds at the display maximum
   always_comb begin
      w_eff  = (CWW'(display_width) > CWW'(MAX_W)) ? WB'(MAX_W) : WB'(display_width);
      h_eff  = (CWH'(display_height) > CWH'(MAX_H)) ? HB'(MAX_H) : HB'(display_height);
      in_clip = (pix.x < COORD_W'(w_eff)) && (pix.y < COORD_W'(h_eff));
      s2_prod_in = PROD_W'(pix.y[HB-1:0]) * PROD_W'(w_eff);
      addr_sum   = EXT_W'(s2_prod_ff) + EXT_W'(s2_x_ff);
   end

   assign out_ok    = !out_v_ff || rsp_bus.ready;
   assign s2_ok     = !s2_v_ff || out_ok;
   assign pix_ready = s2_ok;

   always_comb begin
      s2_v_in  = pix_valid ? 1'b1 : (out_ok ? 1'b0 : s2_v_ff);
      out_v_in = (s2_v_ff && out_ok) ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_valid && s2_ok) begin
         s2_x_ff    <= pix.x;
         s2_y_ff    <= pix.y;
         s2_in_ff   <= in_clip;
         s2_last_ff <= pix.last;
         s2_prod_ff <= s2_prod_in;
      end
      if (s2_v_ff && out_ok) begin
         rsp_bus.in_bounds <= s2_in_ff;
         rsp_bus.pixel_x   <= s2_x_ff;
         rsp_bus.pixel_y   <= s2_y_ff;
         rsp_bus.address   <= s2_in_ff ? addr_sum[ADDR_W-1:0] : '0;
         rsp_bus.color     <= pen_color;
         rsp_bus.last      <= s2_last_ff;
      end
   end

   assign rsp_bus.valid = out_v_ff;

`ifndef SYNTHESIS
   a_clip_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.in_bounds) |-> rsp_bus.address == '0)
      else $error("clipped pixel carries an address");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && !out_ok) |=> s2_v_ff)
      else $error("held pixel lost from the address stage");
`endif

endmodule

FILE: rtl/line_rasterizer_with_clip.sv
// Top level of the Bresenham line rasterizer with display clip.
// Depends on lrc_pkg, lrc_channels, lrc_front, lrc_cmd_queue, lrc_stepper, lrc_pixel_out.
//
//   channel   direction  handshake          carries
//   req_bus   in         valid/ready        operation, x_start, y_start, x_end, y_end
//   rsp_bus   out        valid/ready        in_bounds, pixel_x, pixel_y, address, color, last
//   csr_*     in         write enable only  display_width, display_height, pen_color
//
// One request transfer per cycle is sustained while rsp_bus is ready; a step's pixel reaches
// rsp_bus after its request passes the queue entry, the stepper pixel register, the multiply
// register and the response register. The combinational error add/compare/subtract sets the rate.
// A two-entry queue decouples decode from stepping, so requests keep transferring while
// a finished pixel waits on rsp_bus, until the stages fill and the stall backs up to req_bus.
// Synchronous active-high reset clears all control state and loads the register defaults
// (width 320, height 240, color 0); no clearing pass is needed.
module line_rasterizer_with_clip import lrc_pkg::*; #(
   parameter int MAX_DISPLAY_WIDTH  = 1024,
   parameter int MAX_DISPLAY_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   lrc_req_if.sink               req_bus,
   lrc_rsp_if.source             rsp_bus,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   // configuration registers; the user must write them only while the engine is idle (not enforced)
   logic [CSR_DIM_W-1:0] width_ff, width_in;
   logic [CSR_DIM_W-1:0] height_ff, height_in;
   logic [COLOR_W-1:0]   color_ff, color_in;

   // front end to queue
   logic      push_valid;
   logic      push_ready;
   cmd_type   push_cmd;

   // queue to stepper
   logic      cmd_valid;
   logic      cmd_ready;
   cmd_type   cmd;

   // stepper to clip/address stage
   logic      pix_valid;
   logic      pix_ready;
   pixel_type pix;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      color_in  = color_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DISPLAY_WIDTH:  width_in  = csr_write_data[CSR_DIM_W-1:0];
            CSR_DISPLAY_HEIGHT: height_in = csr_write_data[CSR_DIM_W-1:0];
            CSR_PEN_COLOR:      color_in  = csr_write_data[COLOR_W-1:0];
            default: ;  // unused index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         color_ff  <= COLOR_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         color_ff  <= color_in;
      end
   end

   // decode: a start becomes deltas, directions and the major axis
   lrc_front u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   // short queue so decode and stepping stall independently
   lrc_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (cmd_valid),
      .pop_cmd    (cmd),
      .pop_ready  (cmd_ready)
   );

   // Bresenham state: one command retired per cycle while the pixel output is not stalled
   lrc_stepper u_stepper (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .pix_valid (pix_valid),
      .pix       (pix),
      .pix_ready (pix_ready)
   );

   // clip, y*width+x and the response register
   lrc_pixel_out #(
      .MAX_W (MAX_DISPLAY_WIDTH),
      .MAX_H (MAX_DISPLAY_HEIGHT)
   ) u_pixel_out (
      .clock          (clock),
      .reset          (reset),
      .display_width  (width_ff),
      .display_height (height_ff),
      .pen_color      (color_ff),
      .pix_valid      (pix_valid),
      .pix            (pix),
      .pix_ready      (pix_ready),
      .rsp_bus        (rsp_bus)
   );

endmodule
